FILE: rtl/u3gpf_pkg.sv
// Shared types, constants and CORDIC step functions for the U3 gate pair fusion block.
package u3gpf_pkg;

    // Q4.30 datapath word with headroom for CORDIC growth
    localparam int FX_W = 34;

    typedef logic signed [FX_W-1:0] fx_t;
    typedef logic [31:0]            turn_t;

    localparam fx_t   GAIN_Q30       = 34'sd652032874;
    localparam turn_t QUARTER_TURN   = 32'h4000_0000;
    localparam turn_t HALF_TURN      = 32'h8000_0000;
    localparam turn_t THREE_QUARTERS = 32'hC000_0000;

    // arctangent of 2^-i, in 2^-32 turns
    localparam turn_t ATAN_TAB [0:31] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
        32'h00000000, 32'h00000000
    };

    typedef struct packed {
        fx_t  x;
        fx_t  y;
        fx_t  z;
        logic flip;
    } rot_t;

    typedef struct packed {
        fx_t   x;
        fx_t   y;
        turn_t z;
        logic  zero;
    } vec_t;

    typedef struct packed {
        fx_t re;
        fx_t im;
    } cpx_t;

    typedef struct packed {
        turn_t arg00;
        turn_t arg10;
        turn_t arg11;
        turn_t argn01;
        turn_t theta;
    } side_t;

    function automatic fx_t mulq(fx_t a, fx_t b);
        logic signed [2*FX_W-1:0] p;
        p = a * b;
        return fx_t'(p >>> 30);
    endfunction

    // fold into [-1/4, 1/4) turn, flip flags the negation at the end
    function automatic rot_t rot_fold(turn_t a);
        rot_t  r;
        turn_t b;
        b      = a;
        r.flip = 1'b0;
        if (b >= QUARTER_TURN && b < THREE_QUARTERS)
        begin
            b      = b - HALF_TURN;
            r.flip = 1'b1;
        end
        r.x = GAIN_Q30;
        r.y = '0;
        r.z = fx_t'($signed(b));
        return r;
    endfunction

    function automatic rot_t rot_iter(rot_t r, int i);
        rot_t o;
        fx_t  dx;
        fx_t  dy;
        fx_t  at;
        dx = r.y >>> i;
        dy = r.x >>> i;
        at = $signed({2'b00, ATAN_TAB[i]});
        o  = r;
        if (!r.z[FX_W-1])
        begin
            o.x = r.x - dx;
            o.y = r.y + dy;
            o.z = r.z - at;
        end
        else
        begin
            o.x = r.x + dx;
            o.y = r.y - dy;
            o.z = r.z + at;
        end
        return o;
    endfunction

    function automatic vec_t vec_init(fx_t re, fx_t im);
        vec_t v;
        v.zero = (re == '0) && (im == '0);
        if (re[FX_W-1])
        begin
            v.x = -re;
            v.y = -im;
            v.z = HALF_TURN;
        end
        else
        begin
            v.x = re;
            v.y = im;
            v.z = '0;
        end
        return v;
    endfunction

    function automatic vec_t vec_iter(vec_t v, int i);
        vec_t o;
        fx_t  dx;
        fx_t  dy;
        dx = v.y >>> i;
        dy = v.x >>> i;
        o  = v;
        if (!v.y[FX_W-1])
        begin
            o.x = v.x + dx;
            o.y = v.y - dy;
            o.z = v.z + ATAN_TAB[i];
        end
        else
        begin
            o.x = v.x - dx;
            o.y = v.y + dy;
            o.z = v.z - ATAN_TAB[i];
        end
        return o;
    endfunction

endpackage

FILE: rtl/u3_gate_pair_fusion.sv
// Top level: pipelined fusion of two U3 gates into one U3 gate.
//
// Channel | Dir | Signals                        | Content
// --------+-----+--------------------------------+----------------------------------------
// s_axis  | in  | tvalid tready tdata            | six gate angles (first, then second)
// m_axis  | out | tvalid tready tdata tuser      | fused theta, phi, lambda; degenerate
// cfg     | in  | cfg_we cfg_wdata               | degenerate_threshold, Q1.15
//
// One item enters per cycle unless m_axis stalls; the path runs through four CORDIC
// chains in series: gate building rotations, argument vectoring, half-angle
// vectoring and the sine of the half angle.
// Reset clears the valid pipeline and sets the threshold to 1 LSB; payload is not reset.
// A stall on m_axis freezes every stage at once, so nothing is lost or repeated,
// and s_axis_tready drops only while a finished item waits and is not taken.
module u3_gate_pair_fusion
    import u3gpf_pkg::*;
#(
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16,
    localparam int IN_W  = ((6 * ANGLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((3 * ANGLE_BITS + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [15:0]      cfg_wdata,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // first_theta, first_phi, first_lambda, second_theta, second_phi, second_lambda
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // fused_theta, fused_phi, fused_lambda
    output logic [OUT_W-1:0] m_axis_tdata,
    // degenerate
    output logic             m_axis_tuser
);

    localparam int CS  = CORDIC_STAGES;
    localparam int SH  = 32 - ANGLE_BITS;
    localparam int LAT = 4 * CS + 9;
    localparam logic [32:0] ROUND_ADD = 33'((64'd1 << SH) >> 1);

    typedef logic [ANGLE_BITS-1:0] ang_t;

    // round half up to an output LSB, wrap to the output width
    function automatic ang_t angle_out(turn_t a);
        logic [32:0] v;
        v = {1'b0, a} + ROUND_ADD;
        return v[SH +: ANGLE_BITS];
    endfunction

    function automatic turn_t angle_in(ang_t a);
        return turn_t'(a) << SH;
    endfunction

    // whole pipeline advances together; a waiting item at the output holds every stage
    logic ce;
    assign ce            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = ce;

    logic [LAT-1:0] vld_reg;
    logic [15:0]    thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 16'd1;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    assign m_axis_tvalid = vld_reg[LAT-1];

    // ---------------- gate building rotations: eight lanes ----------------
    // lanes per gate: theta/2, lambda, phi, phi+lambda; gate one in 0..3
    rot_t rot1_reg [0:CS][0:7];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int g = 0; g < 2; g++)
            begin
                rot1_reg[0][4*g]   <= rot_fold(angle_in(s_axis_tdata[(3*g)*ANGLE_BITS +:
                                                                     ANGLE_BITS]) >> 1);
                rot1_reg[0][4*g+1] <= rot_fold(angle_in(s_axis_tdata[(3*g+2)*ANGLE_BITS +:
                                                                     ANGLE_BITS]));
                rot1_reg[0][4*g+2] <= rot_fold(angle_in(s_axis_tdata[(3*g+1)*ANGLE_BITS +:
                                                                     ANGLE_BITS]));
                rot1_reg[0][4*g+3] <= rot_fold(
                    angle_in(s_axis_tdata[(3*g+1)*ANGLE_BITS +: ANGLE_BITS]) +
                    angle_in(s_axis_tdata[(3*g+2)*ANGLE_BITS +: ANGLE_BITS]));
            end
            for (int k = 0; k < CS; k++)
            begin
                for (int l = 0; l < 8; l++)
                begin
                    rot1_reg[k+1][l] <= rot_iter(rot1_reg[k][l], k);
                end
            end
        end
    end

    // ---------------- matrix entries of each gate ----------------
    fx_t  cos_v [0:7];
    fx_t  sin_v [0:7];
    cpx_t gate_reg [0:1][0:3];

    always_comb
    begin
        for (int l = 0; l < 8; l++)
        begin
            cos_v[l] = rot1_reg[CS][l].flip ? -rot1_reg[CS][l].x : rot1_reg[CS][l].x;
            sin_v[l] = rot1_reg[CS][l].flip ? -rot1_reg[CS][l].y : rot1_reg[CS][l].y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int g = 0; g < 2; g++)
            begin
                gate_reg[g][0].re <= cos_v[4*g];
                gate_reg[g][0].im <= '0;
                gate_reg[g][1].re <= -mulq(cos_v[4*g+1], sin_v[4*g]);
                gate_reg[g][1].im <= -mulq(sin_v[4*g+1], sin_v[4*g]);
                gate_reg[g][2].re <= mulq(cos_v[4*g+2], sin_v[4*g]);
                gate_reg[g][2].im <= mulq(sin_v[4*g+2], sin_v[4*g]);
                gate_reg[g][3].re <= mulq(cos_v[4*g+3], cos_v[4*g]);
                gate_reg[g][3].im <= mulq(sin_v[4*g+3], cos_v[4*g]);
            end
        end
    end

    // ---------------- second * first: products, then sums ----------------
    // entry e = 2*row + col takes g2[2row]*g1[col] + g2[2row+1]*g1[2+col]
    fx_t  prod_reg [0:3][0:1][0:3];
    cpx_t rmat_reg [0:3];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int e = 0; e < 4; e++)
            begin
                for (int k = 0; k < 2; k++)
                begin
                    prod_reg[e][k][0] <= mulq(gate_reg[1][2*(e/2)+k].re,
                                              gate_reg[0][(e%2)+2*k].re);
                    prod_reg[e][k][1] <= mulq(gate_reg[1][2*(e/2)+k].im,
                                              gate_reg[0][(e%2)+2*k].im);
                    prod_reg[e][k][2] <= mulq(gate_reg[1][2*(e/2)+k].re,
                                              gate_reg[0][(e%2)+2*k].im);
                    prod_reg[e][k][3] <= mulq(gate_reg[1][2*(e/2)+k].im,
                                              gate_reg[0][(e%2)+2*k].re);
                end
                rmat_reg[e].re <= (prod_reg[e][0][0] - prod_reg[e][0][1]) +
                                  (prod_reg[e][1][0] - prod_reg[e][1][1]);
                rmat_reg[e].im <= (prod_reg[e][0][2] + prod_reg[e][0][3]) +
                                  (prod_reg[e][1][2] + prod_reg[e][1][3]);
            end
        end
    end

    // ---------------- argument vectoring: r00, r10, r11, -r01 ----------------
    vec_t v1_reg [0:CS][0:3];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            v1_reg[0][0] <= vec_init(rmat_reg[0].re, rmat_reg[0].im);
            v1_reg[0][1] <= vec_init(rmat_reg[2].re, rmat_reg[2].im);
            v1_reg[0][2] <= vec_init(rmat_reg[3].re, rmat_reg[3].im);
            v1_reg[0][3] <= vec_init(-rmat_reg[1].re, -rmat_reg[1].im);
            for (int k = 0; k < CS; k++)
            begin
                for (int l = 0; l < 4; l++)
                begin
                    v1_reg[k+1][l] <= vec_iter(v1_reg[k][l], k);
                end
            end
        end
    end

    // zero vector: argument and magnitude both zero
    side_t args_reg;
    fx_t   mag00_reg;
    fx_t   mag10_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            args_reg.arg00  <= v1_reg[CS][0].zero ? '0 : v1_reg[CS][0].z;
            args_reg.arg10  <= v1_reg[CS][1].zero ? '0 : v1_reg[CS][1].z;
            args_reg.arg11  <= v1_reg[CS][2].zero ? '0 : v1_reg[CS][2].z;
            args_reg.argn01 <= v1_reg[CS][3].zero ? '0 : v1_reg[CS][3].z;
            args_reg.theta  <= '0;
            mag00_reg       <= v1_reg[CS][0].zero ? '0 : mulq(v1_reg[CS][0].x, GAIN_Q30);
            mag10_reg       <= v1_reg[CS][1].zero ? '0 : mulq(v1_reg[CS][1].x, GAIN_Q30);
        end
    end

    // ---------------- half angle: atan2(|r10|, |r00|) ----------------
    vec_t  v2_reg   [0:CS];
    side_t v2s_reg  [0:CS];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            v2_reg[0]  <= vec_init(mag00_reg, mag10_reg);
            v2s_reg[0] <= args_reg;
            for (int k = 0; k < CS; k++)
            begin
                v2_reg[k+1]  <= vec_iter(v2_reg[k], k);
                v2s_reg[k+1] <= v2s_reg[k];
            end
        end
    end

    // clamp to [0, 1/4 turn]
    turn_t half_next;
    side_t side_next;

    always_comb
    begin
        half_next = v2_reg[CS].zero ? '0 : v2_reg[CS].z;
        if (half_next >= HALF_TURN)
        begin
            half_next = '0;
        end
        else if (half_next > QUARTER_TURN)
        begin
            half_next = QUARTER_TURN;
        end
        side_next       = v2s_reg[CS];
        side_next.theta = half_next << 1;
    end

    // ---------------- sin(theta/2) ----------------
    rot_t  r2_reg  [0:CS];
    side_t r2s_reg [0:CS];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            r2_reg[0]  <= rot_fold(half_next);
            r2s_reg[0] <= side_next;
            for (int k = 0; k < CS; k++)
            begin
                r2_reg[k+1]  <= rot_iter(r2_reg[k], k);
                r2s_reg[k+1] <= r2s_reg[k];
            end
        end
    end

    // ---------------- degenerate test and output register ----------------
    fx_t   sin_next;
    fx_t   sq15_next;
    logic  deg_next;
    turn_t phi_next;
    turn_t lam_next;

    // a negative sine counts as zero, which sits below any nonzero threshold
    always_comb
    begin
        sin_next  = r2_reg[CS].flip ? -r2_reg[CS].y : r2_reg[CS].y;
        sq15_next = sin_next >>> 15;
        deg_next  = sq15_next[FX_W-1] ? (thr_reg != 16'd0)
                                      : (sq15_next < $signed({18'b0, thr_reg}));
        phi_next  = r2s_reg[CS].arg10 - r2s_reg[CS].arg00;
        lam_next  = (deg_next ? r2s_reg[CS].arg11 : r2s_reg[CS].argn01) -
                    r2s_reg[CS].arg00;
    end

    ang_t theta_o_reg;
    ang_t phi_o_reg;
    ang_t lam_o_reg;
    logic deg_o_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            theta_o_reg <= angle_out(r2s_reg[CS].theta);
            phi_o_reg   <= deg_next ? '0 : angle_out(phi_next);
            lam_o_reg   <= angle_out(lam_next);
            deg_o_reg   <= deg_next;
        end
    end

    assign m_axis_tdata = OUT_W'({lam_o_reg, phi_o_reg, theta_o_reg});
    assign m_axis_tuser = deg_o_reg;

    // ---------------- checks ----------------
    a_deg_phi_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> phi_o_reg == '0)
        else $error("degenerate item with nonzero phi");

    a_theta_half_turn: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(theta_o_reg[ANGLE_BITS-1] && |theta_o_reg[ANGLE_BITS-2:0]))
        else $error("fused theta beyond half a turn");

    a_zero_thr_no_deg: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && thr_reg == 16'd0 |-> !m_axis_tuser)
        else $error("degenerate flagged with zero threshold");

endmodule
